[rtl/i2a_pkg.sv]
// Shared types, character constants and the digit-to-ASCII function
// for the integer-to-ASCII converter. No dependencies.
`timescale 1ns / 1ps

package i2a_pkg;

    // command codes
    localparam logic [1:0] CMD_SIGNED_DEC   = 2'd0;
    localparam logic [1:0] CMD_UNSIGNED_DEC = 2'd1;
    localparam logic [1:0] CMD_HEX_LOWER    = 2'd2;
    localparam logic [1:0] CMD_HEX_UPPER    = 2'd3;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 32-bit v
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic emit_step;
        logic sel_sign;
    } ctrl_cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic neg;
        logic one_left;
    } dp_status_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d < 4'd10) begin
            return CHAR_ZERO + {4'b0000, d};
        end else begin
            return base + {4'b0000, d} - 8'd10;
        end
    endfunction

endpackage

[rtl/i2a_datapath.sv]
// Datapath: number register, divide-by-base step, digit buffer, output mux.
// Depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_datapath (
    input  logic                  aclk,
    input  i2a_pkg::ctrl_cmd_t    cmd,
    output i2a_pkg::dp_status_t   status,
    input  logic [31:0]           s_value,
    input  logic [1:0]            s_command,
    output logic [7:0]            m_text_char,
    output logic                  m_last
);

    logic [31:0]               num_reg;
    logic [31:0]               num_next;
    logic                      neg_reg;
    logic                      hex_reg;
    logic                      upper_reg;
    logic [i2a_pkg::CNT_W-1:0] cnt_reg;
    logic [3:0]                digit_mem [i2a_pkg::MAX_DIGITS];

    logic [63:0]               prod;
    logic [31:0]               quot;
    logic [3:0]                rem;
    logic [3:0]                q_times10_lo;
    logic [i2a_pkg::CNT_W-1:0] rd_cnt;
    logic [i2a_pkg::IDX_W-1:0] rd_idx;
    logic [i2a_pkg::IDX_W-1:0] wr_idx;
    logic                      load_neg;

    // one digit per step: reciprocal multiply for base 10, shift for base 16
    always_comb begin
        prod         = {32'd0, num_reg} * {32'd0, i2a_pkg::RECIP_TEN};
        q_times10_lo = 4'd0;
        if (hex_reg) begin
            quot = {4'd0, num_reg[31:4]};
            rem  = num_reg[3:0];
        end else begin
            quot         = {3'd0, prod[63:i2a_pkg::RECIP_SHIFT]};
            q_times10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
            rem          = num_reg[3:0] - q_times10_lo;
        end
    end

    assign load_neg = (s_command == i2a_pkg::CMD_SIGNED_DEC) && s_value[31];
    assign num_next = load_neg ? (32'd0 - s_value) : s_value;

    assign wr_idx = cnt_reg[i2a_pkg::IDX_W-1:0];
    assign rd_cnt = cnt_reg - {{(i2a_pkg::CNT_W-1){1'b0}}, 1'b1};
    assign rd_idx = rd_cnt[i2a_pkg::IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            num_reg   <= num_next;
            neg_reg   <= load_neg;
            hex_reg   <= s_command[1];
            upper_reg <= (s_command == i2a_pkg::CMD_HEX_UPPER);
            cnt_reg   <= '0;
        end else if (cmd.conv_step) begin
            digit_mem[wr_idx] <= rem;
            num_reg           <= quot;
            cnt_reg           <= cnt_reg + {{(i2a_pkg::CNT_W-1){1'b0}}, 1'b1};
        end else if (cmd.emit_step) begin
            cnt_reg <= rd_cnt;
        end
    end

    always_comb begin
        status.quot_zero = (quot == 32'd0);
        status.neg       = neg_reg;
        status.one_left  = (cnt_reg == {{(i2a_pkg::CNT_W-1){1'b0}}, 1'b1});
    end

    // digits come out of the buffer in reverse of the order they were made
    always_comb begin
        if (cmd.sel_sign) begin
            m_text_char = i2a_pkg::CHAR_MINUS;
            m_last      = 1'b0;
        end else begin
            m_text_char = i2a_pkg::digit_char(digit_mem[rd_idx], upper_reg);
            m_last      = status.one_left;
        end
    end

endmodule

[rtl/i2a_ctrl.sv]
// Controller: sequences load, digit conversion and character emission.
// Depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  i2a_pkg::dp_status_t   status,
    output i2a_pkg::ctrl_cmd_t    cmd
);

    i2a_pkg::state_t state_reg;
    i2a_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2a_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd.load      = 1'b0;
        cmd.conv_step = 1'b0;
        cmd.emit_step = 1'b0;
        cmd.sel_sign  = 1'b0;
        unique case (state_reg)
            i2a_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = i2a_pkg::ST_CONV;
                end
            end
            i2a_pkg::ST_CONV: begin
                cmd.conv_step = 1'b1;
                if (status.quot_zero) begin
                    state_next = status.neg ? i2a_pkg::ST_SIGN : i2a_pkg::ST_DIGIT;
                end
            end
            i2a_pkg::ST_SIGN: begin
                m_valid      = 1'b1;
                cmd.sel_sign = 1'b1;
                if (m_ready) begin
                    state_next = i2a_pkg::ST_DIGIT;
                end
            end
            i2a_pkg::ST_DIGIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.emit_step = 1'b1;
                    if (status.one_left) begin
                        state_next = i2a_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    // input and output sides are never open together
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a character is offered");

    // an accepted item is always followed by a conversion step, with no character offered
    a_conv_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cmd.conv_step && !m_valid))
        else $error("no conversion step after load");

    // the final digit taken returns the block to accepting input
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !cmd.sel_sign && status.one_left) |=> s_ready)
        else $error("not ready after the last character");

    // the sign is never the last character of an item
    a_sign_then_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && cmd.sel_sign) |=> (m_valid && !cmd.sel_sign))
        else $error("sign not followed by digits");

endmodule

[rtl/integer_to_ascii_digits.sv]
// Integer-to-ASCII converter top level: controller plus datapath.
// Conversion makes one digit per cycle, D digits in all, where D is the
// digit count (1..10 decimal, 1..8 hex); then m_valid rises.
// A new item is accepted only once the previous one's last character is
// taken (serial convert, then serial emit); a minus sign adds one character.
// Reset (aresetn, synchronous, active low) returns the controller to idle.
`timescale 1ns / 1ps

module integer_to_ascii_digits (
    input  logic        aclk,
    input  logic        aresetn,
    // input item: word and format command
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    input  logic [1:0]  s_command,
    // result item: one character, last marks the end of the number
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_text_char,
    output logic        m_last
);

    i2a_pkg::ctrl_cmd_t  cmd;
    i2a_pkg::dp_status_t status;

    // Controller: idle -> convert (one digit per cycle, least significant
    // first, into the digit buffer) -> optional sign -> digits read back
    // most significant first. Payload is held stable by the datapath
    // registers while the output stalls.
    i2a_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: magnitude register, base-10 reciprocal multiply or
    // base-16 shift, ten-entry digit buffer and the output character mux.
    i2a_datapath u_datapath (
        .aclk        (aclk),
        .cmd         (cmd),
        .status      (status),
        .s_value     (s_value),
        .s_command   (s_command),
        .m_text_char (m_text_char),
        .m_last      (m_last)
    );

endmodule

[sim/integer_to_ascii_digits_checker.sv]
// Checker for the integer-to-ASCII converter: watches both channels, predicts
// the characters of every accepted word and compares them. Uses i2a_pkg.
`timescale 1ns / 1ps

module integer_to_ascii_digits_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_value,
    input  logic [1:0]  s_command,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_text_char,
    input  logic        m_last,
    output int          fail_count,
    output int          pending_chars
);

    typedef struct packed {
        logic [7:0] glyph;
        logic       last;
    } text_item_t;

    text_item_t expected_text[$];

    // Appends the characters of one word, most significant first.
    function automatic void spell_word(input logic [31:0] word, input logic [1:0] cmd);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [3:0]  nibble;
        logic        negative;
        logic [7:0]  rev_glyphs[$];
        text_item_t  item;
        negative = (cmd == i2a_pkg::CMD_SIGNED_DEC) && word[31];
        mag = negative ? 32'd0 - word : word;
        radix = (cmd == i2a_pkg::CMD_HEX_LOWER || cmd == i2a_pkg::CMD_HEX_UPPER) ?
                32'd16 : 32'd10;
        do begin
            nibble = 4'(mag % radix);
            if (nibble < 4'd10) begin
                rev_glyphs.push_back(i2a_pkg::CHAR_ZERO + {4'b0000, nibble});
            end else if (cmd == i2a_pkg::CMD_HEX_UPPER) begin
                rev_glyphs.push_back(i2a_pkg::CHAR_UPPER_A + {4'b0000, nibble} - 8'd10);
            end else begin
                rev_glyphs.push_back(i2a_pkg::CHAR_LOWER_A + {4'b0000, nibble} - 8'd10);
            end
            mag = mag / radix;
        end while (mag != 32'd0);
        if (negative) begin
            item.glyph = i2a_pkg::CHAR_MINUS;
            item.last  = 1'b0;
            expected_text.push_back(item);
        end
        while (rev_glyphs.size() > 0) begin
            item.glyph = rev_glyphs.pop_back();
            item.last  = (rev_glyphs.size() == 0);
            expected_text.push_back(item);
        end
    endfunction

    initial begin
        fail_count    = 0;
        pending_chars = 0;
    end

    always @(posedge aclk) begin
        text_item_t want;
        if (aresetn) begin
            // result side first: a character taken now belongs to an older word
            if (m_valid && m_ready) begin
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected char %h last %b", $time, m_text_char, m_last);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_text.pop_front();
                    if (m_text_char !== want.glyph) begin
                        $display("%0t: text_char expected %h, got %h",
                                 $time, want.glyph, m_text_char);
                        fail_count = fail_count + 1;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last expected %b, got %b", $time, want.last, m_last);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                spell_word(s_value, s_command);
            end
            pending_chars = expected_text.size();
        end
    end

endmodule

[sim/integer_to_ascii_digits_test.sv]
// Regression top for integer_to_ascii_digits: clock, reset, word stimulus,
// result sink and verdict. Needs i2a_pkg and integer_to_ascii_digits_checker.
`timescale 1ns / 1ps

module integer_to_ascii_digits_test;

    localparam int RANDOM_WORDS    = 390;
    localparam int HOLD_OFF_CYCLES = 400;   // long sink stall, fills the block
    localparam int STALL_LIMIT     = 5000;  // cycles with no item moved
    localparam int TAIL_CYCLES     = 40;    // > worst case for one word with a free sink

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [31:0] s_value     = 32'd0;
    logic [1:0]  s_command   = i2a_pkg::CMD_SIGNED_DEC;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_text_char;
    logic        m_last;

    int fail_count;
    int pending_chars;
    int idle_cycles = 0;
    bit quiet_phase = 1'b0;  // both sides run without gaps while set

    integer_to_ascii_digits u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_command   (s_command),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last      (m_last)
    );

    integer_to_ascii_digits_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_command     (s_command),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_text_char   (m_text_char),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hang shows up as a long run of cycles where no item moves.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("integer_to_ascii_digits regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one word. Valid stays high between back-to-back words, so it is
    // only lowered when a gap is drawn; payload changes only with a new offer.
    task automatic offer_word(input logic [31:0] word, input logic [1:0] cmd);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_value   <= word;
        s_command <= cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Sender goes quiet until every predicted character has come out.
    task automatic drain_text;
        s_valid <= 1'b0;
        while (pending_chars != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    // Random word, biased toward digit-count and sign boundaries.
    function automatic logic [31:0] pick_word;
        logic [31:0] word;
        int          k;
        case ($urandom_range(0, 5))
            0, 1: word = $urandom;
            2: word = $urandom_range(0, 300);
            3: begin
                // around a power of ten, either sign
                word = 32'd1;
                k = $urandom_range(0, 9);
                repeat (k) word = word * 32'd10;
                word = word + 32'($urandom_range(0, 2)) - 32'd1;
                if ($urandom_range(0, 1) == 1) word = 32'd0 - word;
            end
            4: word = (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
            default: word = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
        endcase
        return word;
    endfunction

    // Result sink: random stalls per character, plus long hold-offs at two character counts while
    // the sender keeps offering, so the block backs up into s_ready.
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (taken == 300 || taken == 2200) begin
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = quiet_phase ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
            @(negedge aclk);
        end
    end

    initial begin : word_source
        int n;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero gives a lone '0' in every form
        offer_word(32'd0, i2a_pkg::CMD_SIGNED_DEC);
        offer_word(32'd0, i2a_pkg::CMD_UNSIGNED_DEC);
        offer_word(32'd0, i2a_pkg::CMD_HEX_LOWER);
        offer_word(32'd0, i2a_pkg::CMD_HEX_UPPER);
        // all ones: -1 signed, widest unsigned and hex
        offer_word(32'hFFFF_FFFF, i2a_pkg::CMD_SIGNED_DEC);
        offer_word(32'hFFFF_FFFF, i2a_pkg::CMD_UNSIGNED_DEC);
        offer_word(32'hFFFF_FFFF, i2a_pkg::CMD_HEX_LOWER);
        offer_word(32'hFFFF_FFFF, i2a_pkg::CMD_HEX_UPPER);
        // most negative word: 11 characters signed, no sign otherwise
        offer_word(32'h8000_0000, i2a_pkg::CMD_SIGNED_DEC);
        offer_word(32'h8000_0000, i2a_pkg::CMD_UNSIGNED_DEC);
        offer_word(32'h8000_0000, i2a_pkg::CMD_HEX_UPPER);
        offer_word(32'h7FFF_FFFF, i2a_pkg::CMD_SIGNED_DEC);
        offer_word(32'd1, i2a_pkg::CMD_SIGNED_DEC);
        offer_word(32'hFFFF_FFF6, i2a_pkg::CMD_SIGNED_DEC);
        offer_word(32'd9, i2a_pkg::CMD_UNSIGNED_DEC);
        offer_word(32'd10, i2a_pkg::CMD_UNSIGNED_DEC);
        offer_word(32'd999_999_999, i2a_pkg::CMD_UNSIGNED_DEC);
        offer_word(32'd1_000_000_000, i2a_pkg::CMD_UNSIGNED_DEC);
        // every hex letter in both cases
        offer_word(32'hABCD_EF01, i2a_pkg::CMD_HEX_LOWER);
        offer_word(32'hABCD_EF01, i2a_pkg::CMD_HEX_UPPER);
        offer_word(32'h0000_000F, i2a_pkg::CMD_HEX_LOWER);
        offer_word(32'h1000_0000, i2a_pkg::CMD_HEX_UPPER);
        drain_text();

        for (n = 0; n < RANDOM_WORDS; n++) begin
            quiet_phase = (n >= 150 && n < 200);
            if (n == 260) drain_text();
            offer_word(pick_word(), 2'($urandom_range(0, 3)));
        end
        quiet_phase = 1'b0;
        drain_text();
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (fail_count == 0 && pending_chars == 0) begin
            $display("integer_to_ascii_digits regression: pass");
        end else begin
            $display("integer_to_ascii_digits regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/i2a_pkg.sv
rtl/i2a_datapath.sv
rtl/i2a_ctrl.sv
rtl/integer_to_ascii_digits.sv
sim/integer_to_ascii_digits_checker.sv
sim/integer_to_ascii_digits_test.sv
